// File: rtl/face_vertex_bake_core_assert.svh
// Assertion macros used by face_vertex_bake_core.
`ifndef FACE_VERTEX_BAKE_CORE_ASSERT_SVH
`define FACE_VERTEX_BAKE_CORE_ASSERT_SVH

// Checked at every clock edge outside reset.
`define FVB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define FVB_ASSERT_ALL(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/fvb_pkg.sv
package fvb_pkg;

    localparam int COORD_BITS   = 20;
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;
    localparam int NSTEPS       = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam int CNT_W        = (NSTEPS > 1) ? $clog2(NSTEPS) : 1;
    localparam int ATAN_IW      = 5;

    localparam int CFG_W  = 60;
    localparam int CIDX_W = 3;
    localparam int POS_W  = 20;
    localparam int UV_W   = 17;
    localparam int ANG_W  = 15;
    localparam int ANGX_W = 16;

    // Rotation datapath widths.
    localparam int CSW    = 27;
    localparam int RW     = COORD_BITS + 1;
    localparam int PW     = CSW + RW;
    localparam int ROT_W  = PW + 1 - 24;
    localparam int SCW    = 26;
    localparam int MW     = ROT_W + SCW;
    localparam int RND_W  = MW + 1 - 24;
    localparam int FIN_W  = RND_W + 1;

    // Texture map widths.
    localparam int T_W    = 27;
    localparam int D_W    = 18;
    localparam int P_W    = T_W + 1 + D_W;
    localparam int PS_W   = P_W + 1;
    localparam int V_W    = PS_W - 16;
    localparam int X_W    = 28;
    localparam int M_W    = 29;
    localparam int RP_W   = X_W + M_W;
    localparam int Q0_W   = RP_W - 38;
    localparam int Q_W    = Q0_W + 1;
    localparam int R_W    = Q_W + 2;

    localparam logic [M_W-1:0]        RECIP_1000 = M_W'(274877906);
    localparam logic signed [CSW-1:0] CORDIC_GAIN = CSW'(10188013);
    localparam logic signed [SCW-1:0] SEC_22_5 = SCW'(18159528);
    localparam logic signed [SCW-1:0] SEC_45   = SCW'(23726566);
    localparam logic [31:0] SHADE_WHITE = 32'hFFFFFFFF;
    localparam logic [7:0]  ALPHA_FULL  = 8'hFF;
    localparam logic [UV_W-1:0] TEX_MAX = UV_W'(65536);

    localparam logic signed [FIN_W-1:0] PMAX =
        FIN_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [FIN_W-1:0] PMIN = -PMAX - FIN_W'(1);

    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    typedef enum logic [CIDX_W-1:0] {
        REG_BOX_LO, REG_BOX_HI, REG_PIVOT, REG_AXIS, REG_ANGLE, REG_RESCALE
    } t_reg_idx;

    typedef enum logic [1:0] {C_IDLE, C_LOAD, C_RUN} t_cstate;

    typedef struct packed {
        logic                  busy;
        logic signed [CSW-1:0] cos_v;
        logic signed [CSW-1:0] sin_v;
        logic signed [CSW-1:0] sin_n;
    } t_trig;

    function automatic logic [21:0] atan_deg(input logic [ATAN_IW-1:0] i);
        unique case (i)
            5'd0:  return 22'd2949120;
            5'd1:  return 22'd1740967;
            5'd2:  return 22'd919879;
            5'd3:  return 22'd466945;
            5'd4:  return 22'd234379;
            5'd5:  return 22'd117304;
            5'd6:  return 22'd58666;
            5'd7:  return 22'd29335;
            5'd8:  return 22'd14668;
            5'd9:  return 22'd7334;
            5'd10: return 22'd3667;
            5'd11: return 22'd1833;
            5'd12: return 22'd917;
            5'd13: return 22'd458;
            5'd14: return 22'd229;
            5'd15: return 22'd115;
            5'd16: return 22'd57;
            5'd17: return 22'd29;
            5'd18: return 22'd14;
            5'd19: return 22'd7;
            5'd20: return 22'd4;
            5'd21: return 22'd2;
            5'd22: return 22'd1;
            default: return 22'd0;
        endcase
    endfunction

    // Bit 2 picks high x, bit 1 high y, bit 0 high z.
    function automatic logic [2:0] corner_sel(input logic [2:0] face,
                                              input logic [1:0] corner);
        logic [11:0] row;
        unique case (face)
            3'd0: row = {3'd5, 3'd4, 3'd0, 3'd1};
            3'd1: row = {3'd6, 3'd7, 3'd3, 3'd2};
            3'd2: row = {3'd2, 3'd0, 3'd4, 3'd6};
            3'd3: row = {3'd7, 3'd5, 3'd1, 3'd3};
            3'd4: row = {3'd3, 3'd1, 3'd0, 3'd2};
            3'd5: row = {3'd6, 3'd4, 3'd5, 3'd7};
            default: row = 12'd0;
        endcase
        return row[3*corner +: 3];
    endfunction

    function automatic logic [7:0] grey(input logic [2:0] face);
        unique case (face)
            3'd0: return 8'd127;
            3'd2, 3'd3: return 8'd204;
            3'd4, 3'd5: return 8'd153;
            default: return 8'd255;
        endcase
    endfunction

    function automatic logic signed [COORD_BITS-1:0] coord(input logic [CFG_W-1:0] w,
                                                           input logic [1:0] k);
        logic [63:0] wide;
        int unsigned sh;
        wide = 64'(w);
        sh = 32'(k) * COORD_BITS;
        if (sh >= 64) begin
            return '0;
        end
        wide = wide >> sh;
        return wide[COORD_BITS-1:0];
    endfunction

endpackage

// File: rtl/face_vertex_bake_core.sv
// Channel  Direction  Handshake          Payload
// config   in         i_cfg_wr_en        i_cfg_index, i_cfg_data
// vertex   in         i_valid / o_ready  corner, face, shade, UV and sprite fields
// result   out        o_valid / i_ready  o_pos_x/y/z, o_shade_argb, o_tex_u/v
//
// One vertex beat is accepted per cycle unless the pipeline stalls or the trig unit is busy.
// The six stages are: corner select, multiply, round, stretch multiply,
// quotient estimate and saturation, final texture sum.
// After reset and after each angle write, the sine and cosine unit runs with o_ready low.
// Each stage holds its beat while the one after it is full and stalled.
`include "face_vertex_bake_core_assert.svh"

module face_vertex_bake_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [fvb_pkg::CIDX_W-1:0]            i_cfg_index,
    input  logic [fvb_pkg::CFG_W-1:0]             i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [1:0]                            i_corner_number,
    input  logic [2:0]                            i_face_side,
    input  logic                                  i_shade_on,
    input  logic [1:0]                            i_uv_turns,
    input  logic [fvb_pkg::UV_W-1:0]              i_uv_start_u,
    input  logic [fvb_pkg::UV_W-1:0]              i_uv_start_v,
    input  logic [fvb_pkg::UV_W-1:0]              i_uv_end_u,
    input  logic [fvb_pkg::UV_W-1:0]              i_uv_end_v,
    input  logic [fvb_pkg::UV_W-1:0]              i_sprite_u_low,
    input  logic [fvb_pkg::UV_W-1:0]              i_sprite_u_high,
    input  logic [fvb_pkg::UV_W-1:0]              i_sprite_v_low,
    input  logic [fvb_pkg::UV_W-1:0]              i_sprite_v_high,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [fvb_pkg::POS_W-1:0]      o_pos_x,
    output logic signed [fvb_pkg::POS_W-1:0]      o_pos_y,
    output logic signed [fvb_pkg::POS_W-1:0]      o_pos_z,
    output logic [31:0]                           o_shade_argb,
    output logic [fvb_pkg::UV_W-1:0]              o_tex_u,
    output logic [fvb_pkg::UV_W-1:0]              o_tex_v
);

    localparam int CB    = fvb_pkg::COORD_BITS;
    localparam int RW    = fvb_pkg::RW;
    localparam int PW    = fvb_pkg::PW;
    localparam int ROT_W = fvb_pkg::ROT_W;
    localparam int MW    = fvb_pkg::MW;
    localparam int RND_W = fvb_pkg::RND_W;
    localparam int FIN_W = fvb_pkg::FIN_W;
    localparam int UV_W  = fvb_pkg::UV_W;
    localparam int T_W   = fvb_pkg::T_W;
    localparam int D_W   = fvb_pkg::D_W;
    localparam int P_W   = fvb_pkg::P_W;
    localparam int PS_W  = fvb_pkg::PS_W;
    localparam int V_W   = fvb_pkg::V_W;
    localparam int X_W   = fvb_pkg::X_W;
    localparam int RP_W  = fvb_pkg::RP_W;
    localparam int Q0_W  = fvb_pkg::Q0_W;
    localparam int Q_W   = fvb_pkg::Q_W;
    localparam int R_W   = fvb_pkg::R_W;

    // Configuration registers.
    logic [fvb_pkg::CFG_W-1:0] r_box_lo, r_box_hi, r_pivot;
    logic [1:0] r_turn_axis;
    logic signed [fvb_pkg::ANG_W-1:0] r_turn_angle;
    logic r_rescale;
    logic w_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_lo     <= '0;
            r_box_hi     <= '0;
            r_pivot      <= '0;
            r_turn_axis  <= fvb_pkg::AXIS_NONE;
            r_turn_angle <= '0;
            r_rescale    <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                fvb_pkg::REG_BOX_LO:  r_box_lo     <= i_cfg_data;
                fvb_pkg::REG_BOX_HI:  r_box_hi     <= i_cfg_data;
                fvb_pkg::REG_PIVOT:   r_pivot      <= i_cfg_data;
                fvb_pkg::REG_AXIS:    r_turn_axis  <= i_cfg_data[1:0];
                fvb_pkg::REG_ANGLE:   r_turn_angle <= i_cfg_data[fvb_pkg::ANG_W-1:0];
                fvb_pkg::REG_RESCALE: r_rescale    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_start = i_cfg_wr_en && (i_cfg_index == fvb_pkg::REG_ANGLE);

    fvb_pkg::t_trig w_trig;

    fvb_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_angle (r_turn_angle),
        .o_trig  (w_trig)
    );

    // Static per-configuration controls.
    logic [2:0] w_off;
    logic w_stretch;
    logic signed [fvb_pkg::SCW-1:0] w_sec;
    logic signed [fvb_pkg::CSW-1:0] w_sin_sel;
    logic signed [CB-1:0] w_org [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_off[k]  = (r_turn_axis != fvb_pkg::AXIS_NONE) && (r_turn_axis != 2'(k));
            w_org[k]  = fvb_pkg::coord(r_pivot, 2'(k));
        end
        w_stretch = r_rescale && (r_turn_axis != fvb_pkg::AXIS_NONE);
        w_sec = (r_turn_angle == 15'sd1440 || r_turn_angle == -15'sd1440) ?
                fvb_pkg::SEC_22_5 : fvb_pkg::SEC_45;
        w_sin_sel = (r_turn_axis == fvb_pkg::AXIS_Y) ? w_trig.sin_n : w_trig.sin_v;
    end

    // Stage handshake.
    logic [6:1] r_vld;
    logic [7:1] w_en;

    always_comb begin
        w_en[7] = i_ready;
        for (int k = 6; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_ready = w_en[1] && !w_trig.busy;
    assign o_valid = r_vld[6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[1]) r_vld[1] <= i_valid && o_ready;
            for (int k = 2; k <= 6; k++) begin
                if (w_en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Stage 1: corner select, offset from pivot, UV corner pick.
    logic signed [RW-1:0] r1_r [3];
    logic signed [RW-1:0] r1_a, r1_b;
    logic [T_W-1:0] r1_t_u, r1_t_v;
    logic signed [D_W-1:0] r1_d_u, r1_d_v;
    logic [UV_W-1:0] r1_lo_u, r1_lo_v;
    logic [31:0] r1_shade;

    logic [2:0] w_sel;
    logic signed [RW-1:0] w_r [3];
    logic [1:0] w_i0, w_i1;
    logic [UV_W-1:0] w_nu, w_fu, w_nv, w_fv;
    logic [7:0] w_g;

    always_comb begin
        w_sel = fvb_pkg::corner_sel(i_face_side, i_corner_number);
        w_r[0] = RW'(fvb_pkg::coord(w_sel[2] ? r_box_hi : r_box_lo, 2'd0)) - RW'(w_org[0]);
        w_r[1] = RW'(fvb_pkg::coord(w_sel[1] ? r_box_hi : r_box_lo, 2'd1)) - RW'(w_org[1]);
        w_r[2] = RW'(fvb_pkg::coord(w_sel[0] ? r_box_hi : r_box_lo, 2'd2)) - RW'(w_org[2]);
        w_i0 = i_corner_number + i_uv_turns;
        w_i1 = w_i0 + 2'd2;
        w_nu = (w_i0 < 2'd2) ? i_uv_start_u : i_uv_end_u;
        w_fu = (w_i1 < 2'd2) ? i_uv_start_u : i_uv_end_u;
        w_nv = (w_i0 == 2'd0 || w_i0 == 2'd3) ? i_uv_start_v : i_uv_end_v;
        w_fv = (w_i1 == 2'd0 || w_i1 == 2'd3) ? i_uv_start_v : i_uv_end_v;
        w_g  = fvb_pkg::grey(i_face_side);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_r <= w_r;
            unique case (r_turn_axis)
                fvb_pkg::AXIS_X: begin r1_a <= w_r[1]; r1_b <= w_r[2]; end
                fvb_pkg::AXIS_Y: begin r1_a <= w_r[0]; r1_b <= w_r[2]; end
                default:         begin r1_a <= w_r[0]; r1_b <= w_r[1]; end
            endcase
            r1_t_u   <= T_W'(w_nu) * T_W'(999) + T_W'(w_fu);
            r1_t_v   <= T_W'(w_nv) * T_W'(999) + T_W'(w_fv);
            r1_d_u   <= $signed(D_W'(i_sprite_u_high)) - $signed(D_W'(i_sprite_u_low));
            r1_d_v   <= $signed(D_W'(i_sprite_v_high)) - $signed(D_W'(i_sprite_v_low));
            r1_lo_u  <= i_sprite_u_low;
            r1_lo_v  <= i_sprite_v_low;
            r1_shade <= i_shade_on ? {fvb_pkg::ALPHA_FULL, w_g, w_g, w_g} :
                        fvb_pkg::SHADE_WHITE;
        end
    end

    // Stage 2: rotation and texture products.
    logic signed [PW-1:0] r2_ca, r2_sb, r2_sa, r2_cb;
    logic signed [RW-1:0] r2_r [3];
    logic signed [P_W-1:0] r2_p_u, r2_p_v;
    logic [UV_W-1:0] r2_lo_u, r2_lo_v;
    logic [31:0] r2_shade;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r2_ca    <= PW'(w_trig.cos_v) * PW'(r1_a);
            r2_sb    <= PW'(w_sin_sel) * PW'(r1_b);
            r2_sa    <= PW'(w_sin_sel) * PW'(r1_a);
            r2_cb    <= PW'(w_trig.cos_v) * PW'(r1_b);
            r2_r     <= r1_r;
            r2_p_u   <= P_W'($signed({1'b0, r1_t_u})) * P_W'(r1_d_u);
            r2_p_v   <= P_W'($signed({1'b0, r1_t_v})) * P_W'(r1_d_v);
            r2_lo_u  <= r1_lo_u;
            r2_lo_v  <= r1_lo_v;
            r2_shade <= r1_shade;
        end
    end

    // Stage 3: round the rotation, fold the texture sum to a magnitude.
    logic signed [ROT_W-1:0] r3_q [3];
    logic [X_W-1:0] r3_x_u, r3_x_v;
    logic r3_neg_u, r3_neg_v;
    logic [UV_W-1:0] r3_lo_u, r3_lo_v;
    logic [31:0] r3_shade;

    logic signed [PW:0] w_sum_a, w_sum_b;
    logic signed [ROT_W-1:0] w_rot_a, w_rot_b;
    logic signed [ROT_W-1:0] w_q [3];
    logic signed [V_W-1:0] w_v_u, w_v_v;
    logic [1:0] w_ia, w_ib;

    always_comb begin
        w_sum_a = (PW+1)'(r2_ca) - (PW+1)'(r2_sb) + (PW+1)'(2**23);
        w_sum_b = (PW+1)'(r2_sa) + (PW+1)'(r2_cb) + (PW+1)'(2**23);
        w_rot_a = ROT_W'(w_sum_a >>> 24);
        w_rot_b = ROT_W'(w_sum_b >>> 24);
        w_ia = (r_turn_axis == fvb_pkg::AXIS_X) ? 2'd1 : 2'd0;
        w_ib = (r_turn_axis == fvb_pkg::AXIS_Z) ? 2'd1 : 2'd2;
        for (int k = 0; k < 3; k++) begin
            w_q[k] = ROT_W'(r2_r[k]);
            if (w_off[k] && 2'(k) == w_ia) w_q[k] = w_rot_a;
            if (w_off[k] && 2'(k) == w_ib) w_q[k] = w_rot_b;
        end
        w_v_u = V_W'((PS_W'(r2_p_u) + PS_W'(32768000)) >>> 16);
        w_v_v = V_W'((PS_W'(r2_p_v) + PS_W'(32768000)) >>> 16);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r3_q     <= w_q;
            r3_neg_u <= w_v_u[V_W-1];
            r3_neg_v <= w_v_v[V_W-1];
            r3_x_u   <= X_W'(w_v_u[V_W-1] ? ~w_v_u : w_v_u);
            r3_x_v   <= X_W'(w_v_v[V_W-1] ? ~w_v_v : w_v_v);
            r3_lo_u  <= r2_lo_u;
            r3_lo_v  <= r2_lo_v;
            r3_shade <= r2_shade;
        end
    end

    // Stage 4: secant stretch and reciprocal products.
    logic signed [ROT_W-1:0] r4_q [3];
    logic signed [MW-1:0] r4_m [3];
    logic [RP_W-1:0] r4_rp_u, r4_rp_v;
    logic [X_W-1:0] r4_x_u, r4_x_v;
    logic r4_neg_u, r4_neg_v;
    logic [UV_W-1:0] r4_lo_u, r4_lo_v;
    logic [31:0] r4_shade;

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r4_q <= r3_q;
            for (int k = 0; k < 3; k++) begin
                r4_m[k] <= MW'(r3_q[k]) * MW'(w_sec);
            end
            r4_rp_u  <= RP_W'(r3_x_u) * RP_W'(fvb_pkg::RECIP_1000);
            r4_rp_v  <= RP_W'(r3_x_v) * RP_W'(fvb_pkg::RECIP_1000);
            r4_x_u   <= r3_x_u;
            r4_x_v   <= r3_x_v;
            r4_neg_u <= r3_neg_u;
            r4_neg_v <= r3_neg_v;
            r4_lo_u  <= r3_lo_u;
            r4_lo_v  <= r3_lo_v;
            r4_shade <= r3_shade;
        end
    end

    // Stage 5: pivot add and saturation; quotient estimate and remainder.
    logic signed [CB-1:0] r5_pos [3];
    logic [Q0_W-1:0] r5_q0_u, r5_q0_v;
    logic [X_W-1:0] r5_rem_u, r5_rem_v;
    logic r5_neg_u, r5_neg_v;
    logic [UV_W-1:0] r5_lo_u, r5_lo_v;
    logic [31:0] r5_shade;

    logic signed [RND_W-1:0] w_pick [3];
    logic signed [FIN_W-1:0] w_fin [3];
    logic signed [CB-1:0] w_sat [3];
    logic [Q0_W-1:0] w_q0_u, w_q0_v;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (w_stretch && w_off[k]) begin
                w_pick[k] = RND_W'(((MW+1)'(r4_m[k]) + (MW+1)'(2**23)) >>> 24);
            end else begin
                w_pick[k] = RND_W'(r4_q[k]);
            end
            w_fin[k] = FIN_W'(w_pick[k]) + FIN_W'(w_org[k]);
            if (w_fin[k] > fvb_pkg::PMAX) begin
                w_sat[k] = CB'(fvb_pkg::PMAX);
            end else if (w_fin[k] < fvb_pkg::PMIN) begin
                w_sat[k] = CB'(fvb_pkg::PMIN);
            end else begin
                w_sat[k] = CB'(w_fin[k]);
            end
        end
        w_q0_u = r4_rp_u[RP_W-1:38];
        w_q0_v = r4_rp_v[RP_W-1:38];
    end

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r5_pos   <= w_sat;
            r5_q0_u  <= w_q0_u;
            r5_q0_v  <= w_q0_v;
            r5_rem_u <= r4_x_u - X_W'(w_q0_u) * X_W'(1000);
            r5_rem_v <= r4_x_v - X_W'(w_q0_v) * X_W'(1000);
            r5_neg_u <= r4_neg_u;
            r5_neg_v <= r4_neg_v;
            r5_lo_u  <= r4_lo_u;
            r5_lo_v  <= r4_lo_v;
            r5_shade <= r4_shade;
        end
    end

    // Stage 6: quotient correction, sprite offset, clamp.
    logic signed [CB-1:0] r6_pos [3];
    logic [UV_W-1:0] r6_tex_u, r6_tex_v;
    logic [31:0] r6_shade;

    function automatic logic [UV_W-1:0] tex_final(input logic [Q0_W-1:0] q0,
                                                  input logic [X_W-1:0] rem,
                                                  input logic neg,
                                                  input logic [UV_W-1:0] lo);
        logic [Q_W-1:0] q;
        logic signed [R_W-1:0] fq, sum;
        q   = Q_W'(q0) + Q_W'(rem >= X_W'(1000));
        fq  = neg ? -R_W'(1) - R_W'(q) : R_W'(q);
        sum = R_W'(lo) + fq;
        if (sum < 0) begin
            return '0;
        end else if (sum > R_W'(fvb_pkg::TEX_MAX)) begin
            return fvb_pkg::TEX_MAX;
        end
        return UV_W'(sum);
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r6_pos   <= r5_pos;
            r6_tex_u <= tex_final(r5_q0_u, r5_rem_u, r5_neg_u, r5_lo_u);
            r6_tex_v <= tex_final(r5_q0_v, r5_rem_v, r5_neg_v, r5_lo_v);
            r6_shade <= r5_shade;
        end
    end

    assign o_pos_x      = fvb_pkg::POS_W'(r6_pos[0]);
    assign o_pos_y      = fvb_pkg::POS_W'(r6_pos[1]);
    assign o_pos_z      = fvb_pkg::POS_W'(r6_pos[2]);
    assign o_shade_argb = r6_shade;
    assign o_tex_u      = r6_tex_u;
    assign o_tex_v      = r6_tex_v;

    `FVB_ASSERT(a_no_accept_busy, (i_valid && o_ready) |-> !w_trig.busy, "beat accepted while trig busy")
    `FVB_ASSERT(a_stage_hold, (r_vld[3] && !w_en[4]) |=> r_vld[3], "stalled stage lost its beat")
    `FVB_ASSERT(a_tex_range, o_valid |-> (o_tex_u <= fvb_pkg::TEX_MAX && o_tex_v <= fvb_pkg::TEX_MAX), "texture out of range")
    `FVB_ASSERT(a_alpha, o_valid |-> (o_shade_argb[31:24] == fvb_pkg::ALPHA_FULL), "shade not opaque")
    `FVB_ASSERT_ALL(a_reset_clear, !i_rst_n |=> !o_valid, "valid survived reset")

endmodule

// File: rtl/fvb_cordic.sv
module fvb_cordic (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [fvb_pkg::ANG_W-1:0]  i_angle,
    output fvb_pkg::t_trig                    o_trig
);

    localparam int CSW = fvb_pkg::CSW;

    fvb_pkg::t_cstate r_state, n_state;
    logic signed [CSW-1:0] r_x, r_y, r_z, r_cos, r_sin, r_sin_n;
    logic signed [CSW-1:0] n_x, n_y, n_z, w_z0, w_atan;
    logic [fvb_pkg::CNT_W-1:0] r_cnt;
    logic r_neg, w_neg, w_last;
    logic signed [fvb_pkg::ANGX_W-1:0] w_a0, w_a1, w_a2;

    always_comb begin
        w_a0 = fvb_pkg::ANGX_W'(i_angle);
        if (w_a0 > 16'sd11520) begin
            w_a1 = w_a0 - 16'sd23040;
        end else if (w_a0 < -16'sd11520) begin
            w_a1 = w_a0 + 16'sd23040;
        end else begin
            w_a1 = w_a0;
        end
        w_neg = 1'b1;
        if (w_a1 > 16'sd5760) begin
            w_a2 = w_a1 - 16'sd11520;
        end else if (w_a1 < -16'sd5760) begin
            w_a2 = w_a1 + 16'sd11520;
        end else begin
            w_a2 = w_a1;
            w_neg = 1'b0;
        end
        w_z0 = CSW'(w_a2) <<< 10;
    end

    assign w_last = (r_cnt == fvb_pkg::CNT_W'(fvb_pkg::NSTEPS - 1));
    assign w_atan = CSW'(fvb_pkg::atan_deg(fvb_pkg::ATAN_IW'(r_cnt)));

    always_comb begin
        if (r_z >= 0) begin
            n_x = r_x - (r_y >>> r_cnt);
            n_y = r_y + (r_x >>> r_cnt);
            n_z = r_z - w_atan;
        end else begin
            n_x = r_x + (r_y >>> r_cnt);
            n_y = r_y - (r_x >>> r_cnt);
            n_z = r_z + w_atan;
        end
    end

    always_comb begin
        n_state = r_state;
        priority if (i_start) begin
            n_state = fvb_pkg::C_LOAD;
        end else if (r_state == fvb_pkg::C_LOAD) begin
            n_state = fvb_pkg::C_RUN;
        end else if (r_state == fvb_pkg::C_RUN && w_last) begin
            n_state = fvb_pkg::C_IDLE;
        end
    end

    always_comb begin
        o_trig.busy  = (r_state != fvb_pkg::C_IDLE) || i_start;
        o_trig.cos_v = r_cos;
        o_trig.sin_v = r_sin;
        o_trig.sin_n = r_sin_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fvb_pkg::C_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == fvb_pkg::C_LOAD) begin
            r_x   <= fvb_pkg::CORDIC_GAIN;
            r_y   <= '0;
            r_z   <= w_z0;
            r_neg <= w_neg;
            r_cnt <= '0;
        end else if (r_state == fvb_pkg::C_RUN) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
            r_cnt <= r_cnt + fvb_pkg::CNT_W'(1);
            if (w_last) begin
                r_cos   <= r_neg ? -n_x : n_x;
                r_sin   <= r_neg ? -n_y : n_y;
                r_sin_n <= r_neg ? n_y : -n_y;
            end
        end
    end

endmodule
